>>> sv/sfc_pkg.sv
// Shared widths, register indexes and bus types for the sphere frustum culler.
`default_nettype none

package sfc_pkg;

  // Fixed field widths
  localparam int unsigned FIELD_W    = 16;               // Q8.8 matrix / plane / offset terms
  localparam int unsigned MAT_FIELDS = 12;               // three rows of four
  localparam int unsigned IN_DATA_W  = FIELD_W * MAT_FIELDS;
  localparam int unsigned XPROD_W    = 2 * FIELD_W;      // Q8.8 * Q8.8
  localparam int unsigned CTR_W      = 33;               // Q16.16 centre, three products + shift
  localparam int unsigned PROD_W     = FIELD_W + CTR_W;  // normal * centre
  localparam int unsigned DIST_W     = 50;               // Q24.24 plane distance
  localparam int unsigned Q_W        = DIST_W - 8;       // distance after floor shift by 8
  localparam int unsigned OUT_DIST_W = 32;
  localparam int unsigned OUT_DATA_W = 40;               // visible + distance, byte padded
  localparam int unsigned PLANE_REGS = 6;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned OFFSET_W   = 48;
  localparam int unsigned RADIUS_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE0        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_OFFSET = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_RADIUS = 3'd7;

  typedef logic signed [CTR_W-1:0]  ctr_t;
  typedef logic signed [DIST_W-1:0] dist_t;

  // Largest distance: seeds the running minimum in front of the first cell
  localparam dist_t DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Item moving along the cell chain
  typedef struct packed {
    logic  valid;
    ctr_t  cx;
    ctr_t  cy;
    ctr_t  cz;
    dist_t best;
  } cell_bus_t;

endpackage

`default_nettype wire

>>> sv/sfc_xform.sv
// Model-matrix transform of the bounding-sphere offset into a world centre.
`default_nettype none

module sfc_xform import sfc_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  cfg_wr_t                cfg_i,
  input  wire                    valid_i,
  input  wire  [IN_DATA_W-1:0]   data_i,
  output cell_bus_t              bus_o
);

  logic [OFFSET_W-1:0] offset_q;

  logic                            v1_q;
  logic signed [XPROD_W-1:0]       prod_q [3][3];
  logic signed [FIELD_W-1:0]       trans_q [3];
  logic signed [XPROD_W-1:0]       prod_d [3][3];

  logic  v2_q;
  ctr_t  ctr_q [3];
  ctr_t  ctr_d [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_i.we && cfg_i.idx == CFG_SPHERE_OFFSET) begin
      offset_q <= cfg_i.data[OFFSET_W-1:0];
    end
  end

  // stage 1: nine Q8.8 products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(data_i[FIELD_W*(r*4+c) +: FIELD_W])
                     * $signed(offset_q[FIELD_W*c +: FIELD_W]);
      end
    end
  end

  // stage 2: row sums plus translation
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ctr_d[r] = (CTR_W'(trans_q[r]) <<< 8) + CTR_W'(prod_q[r][0])
               + CTR_W'(prod_q[r][1]) + CTR_W'(prod_q[r][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        trans_q[r] <= $signed(data_i[FIELD_W*(r*4+3) +: FIELD_W]);
        ctr_q[r]   <= ctr_d[r];
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= prod_d[r][c];
        end
      end
    end
  end

  assign bus_o.valid = v2_q;
  assign bus_o.cx    = ctr_q[0];
  assign bus_o.cy    = ctr_q[1];
  assign bus_o.cz    = ctr_q[2];
  assign bus_o.best  = DIST_MAX;

endmodule

`default_nettype wire

>>> sv/sfc_cell.sv
// One plane cell: holds its plane, computes the distance, keeps the running minimum.
`default_nettype none

module sfc_cell import sfc_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        en_i,
  input  cfg_wr_t    cfg_i,
  input  cell_bus_t  bus_i,
  output cell_bus_t  bus_o
);

  localparam logic [CFG_IDX_W-1:0] MY_IDX = CFG_PLANE0 + CFG_IDX_W'(CELL_IDX);

  logic [CFG_DATA_W-1:0] plane_q;

  logic signed [FIELD_W-1:0] nx, ny, nz, w;
  logic signed [PROD_W-1:0]  px_d, py_d, pz_d;
  logic signed [PROD_W-1:0]  px_q, py_q, pz_q;
  cell_bus_t                 s1_q;
  cell_bus_t                 bus_q;
  dist_t                     plane_dist;

  assign nx = $signed(plane_q[15:0]);
  assign ny = $signed(plane_q[31:16]);
  assign nz = $signed(plane_q[47:32]);
  assign w  = $signed(plane_q[63:48]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (cfg_i.we && cfg_i.idx == MY_IDX) begin
      plane_q <= cfg_i.data;
    end
  end

  assign px_d = nx * bus_i.cx;
  assign py_d = ny * bus_i.cy;
  assign pz_d = nz * bus_i.cz;

  assign plane_dist = DIST_W'(px_q) + DIST_W'(py_q) + DIST_W'(pz_q) + (DIST_W'(w) <<< 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      bus_q <= '0;
    end else if (en_i) begin
      s1_q.valid <= bus_i.valid;
      s1_q.cx    <= bus_i.cx;
      s1_q.cy    <= bus_i.cy;
      s1_q.cz    <= bus_i.cz;
      s1_q.best  <= bus_i.best;
      bus_q.valid <= s1_q.valid;
      bus_q.cx    <= s1_q.cx;
      bus_q.cy    <= s1_q.cy;
      bus_q.cz    <= s1_q.cz;
      bus_q.best  <= (plane_dist < s1_q.best) ? plane_dist : s1_q.best;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
    end
  end

  assign bus_o = bus_q;

endmodule

`default_nettype wire

>>> sv/sphere_frustum_cull.sv
// Top level of the bounding-sphere frustum culler.
`default_nettype none

// Culls one instance per transaction. Each input transaction carries the top
// three rows of a model matrix (Q8.8); the block moves the configured sphere
// offset through it, measures the centre against the frustum planes and
// returns one result transaction: visible, and the smallest plane distance
// as saturated Q16.16. An instance is kept when that distance (exact, before
// saturation) is greater than minus twice the radius. Throughput is one
// transaction per clock while the skid entry is empty. A two-stage transform
// feeds N = PLANE_COUNT (limited to 1..6) plane cells, each two stages deep
// (multiply, then sum and minimum). The user must write planes and sphere
// registers through the cfg port only while the block is idle; the block
// does not enforce this. A plane register belongs to its cell. A two-deep
// output buffer lets the input flow while a result waits on m_axis_tready_i.
module sphere_frustum_cull import sfc_pkg::*; #(
  parameter int PLANE_COUNT = 6
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // configuration writes
  input  wire                   cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  wire                   s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // row0_col0, row0_col1, row0_col2, row0_col3, row1_col0 .. row2_col3, 16 bits each
  input  wire  [IN_DATA_W-1:0]  s_axis_tdata_i,
  // result stream
  output logic                  m_axis_tvalid_o,
  input  wire                   m_axis_tready_i,
  // visible [0], nearest_plane_distance [32:1], zero pad [39:33]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int NCELL = (PLANE_COUNT > int'(PLANE_REGS)) ? int'(PLANE_REGS) :
                         ((PLANE_COUNT < 1) ? 1 : PLANE_COUNT);

  typedef struct packed {
    logic                          visible;
    logic signed [OUT_DIST_W-1:0]  near_dist;
  } res_t;

  cfg_wr_t   cfg;
  cell_bus_t chain [NCELL+1];
  logic      en;

  logic [RADIUS_W-1:0] radius_q;

  // output register plus skid entry
  logic out_v_q, skid_v_q;
  res_t out_q, skid_q, res_new;
  logic take;

  dist_t                   lim;
  logic signed [Q_W-1:0]   q;
  logic                    q_ovf;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  // whole pipeline moves together; stops only while the skid entry is full
  assign en              = !skid_v_q;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (cfg_we_i && cfg_idx_i == CFG_SPHERE_RADIUS) begin
      radius_q <= cfg_data_i[RADIUS_W-1:0];
    end
  end

  sfc_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg),
    .valid_i (s_axis_tvalid_i),
    .data_i  (s_axis_tdata_i),
    .bus_o   (chain[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    sfc_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cfg_i  (cfg),
      .bus_i  (chain[g]),
      .bus_o  (chain[g+1])
    );
  end

  // visibility on the exact distance; -(2 * radius) in Q24.24 units
  assign lim = DIST_W'(0) - $signed(DIST_W'(radius_q) << 17);

  // floor divide by 256, then saturate to 32 bits
  assign q     = Q_W'(chain[NCELL].best >>> 8);
  assign q_ovf = !((&q[Q_W-1:OUT_DIST_W-1]) || !(|q[Q_W-1:OUT_DIST_W-1]));

  always_comb begin
    res_new.visible = chain[NCELL].best > lim;
    if (q_ovf) begin
      res_new.near_dist = q[Q_W-1] ? {1'b1, {(OUT_DIST_W-1){1'b0}}}
                                   : {1'b0, {(OUT_DIST_W-1){1'b1}}};
    end else begin
      res_new.near_dist = q[OUT_DIST_W-1:0];
    end
  end

  assign take = out_v_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (chain[NCELL].valid) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (chain[NCELL].valid) begin
      if (!out_v_q || take) begin
        out_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-OUT_DIST_W-1){1'b0}}, out_q.near_dist, out_q.visible};

endmodule

`default_nettype wire
